>>> rtl/utrd_pkg.sv
// utrd_pkg: shared types, constants and the digit glyph function
// for the unsigned to radix digits unit; no dependencies
package utrd_pkg;

  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int MAX_DIGITS_DEF = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd65;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT,
    ST_ERR
  } utrd_state_t;

  typedef struct packed {
    logic load;
    logic feed;
    logic shift;
    logic emit;
  } utrd_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic top_sig;
  } utrd_sts_t;

  function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] g;
    if (d < DIGIT_TEN) begin
      g = CHAR_ZERO + CHAR_W'(d);
    end else begin
      g = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
    return g;
  endfunction

endpackage

>>> rtl/utrd_dp.sv
// utrd_dp: datapath, a skewed row of doubling digit cells plus the
// significance flags and the digit shift-out path; uses utrd_pkg
module utrd_dp #(
  parameter int MAX_DIGITS = utrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  utrd_pkg::utrd_cmd_t            cmd,
  input  logic [utrd_pkg::VALUE_W-1:0]   value,
  input  logic [utrd_pkg::RADIX_W-1:0]   radix,
  output utrd_pkg::utrd_sts_t            sts,
  output logic [utrd_pkg::CHAR_W-1:0]    digit_char
);
  import utrd_pkg::*;

  logic [VALUE_W-1:0]    vreg;
  logic [RADIX_W-1:0]    base;
  logic [DIGIT_W-1:0]    cells [MAX_DIGITS];
  logic [MAX_DIGITS-2:0] carry;
  logic [MAX_DIGITS-1:1] en;
  logic [MAX_DIGITS-1:0] sig;

  logic [MAX_DIGITS-1:0] act;
  logic [MAX_DIGITS-1:0] cin;
  logic [MAX_DIGITS-1:0] ge;
  logic [DIGIT_W:0]      sum [MAX_DIGITS];
  logic [DIGIT_W-1:0]    nxt [MAX_DIGITS];

  // cell i works on each value bit after cell i-1, through the registered en and carry flags
  always_comb begin
    act[0] = cmd.feed;
    cin[0] = vreg[VALUE_W-1];
    for (int i = 1; i < MAX_DIGITS; i++) begin
      act[i] = en[i];
      cin[i] = carry[i-1];
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      sum[i] = {cells[i], cin[i]};
      ge[i]  = sum[i] >= {1'b0, base};
      nxt[i] = ge[i] ? DIGIT_W'(sum[i] - {1'b0, base}) : sum[i][DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      en <= '0;
    end else begin
      for (int i = 1; i < MAX_DIGITS; i++) begin
        en[i] <= act[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vreg  <= value;
      base  <= radix;
      carry <= '0;
      sig   <= MAX_DIGITS'(1);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        cells[i] <= '0;
      end
    end else if (cmd.shift) begin
      cells[0] <= '0;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        cells[i] <= cells[i-1];
      end
      sig <= {sig[MAX_DIGITS-2:0], 1'b0};
    end else begin
      if (cmd.feed) begin
        vreg <= {vreg[VALUE_W-2:0], 1'b0};
      end
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (act[i]) begin
          cells[i] <= nxt[i];
        end
      end
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        carry[i] <= act[i] & ge[i];
      end
      // a carry into a cell means that digit is significant
      for (int i = 1; i < MAX_DIGITS; i++) begin
        sig[i] <= sig[i] | (act[i] & cin[i]);
      end
    end
  end

  assign sts.radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign sts.top_sig  = sig[MAX_DIGITS-1];
  assign digit_char   = cmd.emit ? glyph_of(cells[MAX_DIGITS-1]) : '0;

endmodule

>>> rtl/utrd_ctrl.sv
// utrd_ctrl: controller state machine, sequences conversion, leading
// zero skip and digit emission; uses utrd_pkg
module utrd_ctrl #(
  parameter int MAX_DIGITS = utrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  utrd_pkg::utrd_sts_t           sts,
  output utrd_pkg::utrd_cmd_t           cmd,
  output logic                          busy,
  output logic                          strobe,
  output logic [utrd_pkg::COUNT_W-1:0]  digit_count,
  output logic                          last_digit,
  output logic                          bad_radix
);
  import utrd_pkg::*;

  localparam int CONV_LAST = VALUE_W + MAX_DIGITS - 2;
  localparam int TW        = $clog2(CONV_LAST + 1);
  localparam int KW        = $clog2(MAX_DIGITS);

  utrd_state_t        state, state_next;
  logic [TW-1:0]      tcnt, tcnt_next;
  logic [KW-1:0]      skips, skips_next;
  logic [KW-1:0]      ecnt, ecnt_next;
  logic [COUNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tcnt  <= '0;
      skips <= '0;
      ecnt  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      tcnt  <= tcnt_next;
      skips <= skips_next;
      ecnt  <= ecnt_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next  = state;
    tcnt_next   = tcnt;
    skips_next  = skips;
    ecnt_next   = ecnt;
    count_next  = count;
    cmd         = '0;
    busy        = 1'b1;
    strobe      = 1'b0;
    digit_count = '0;
    last_digit  = 1'b0;
    bad_radix   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          tcnt_next  = '0;
          skips_next = '0;
          ecnt_next  = '0;
          state_next = sts.radix_ok ? ST_CONV : ST_ERR;
        end
      end
      ST_CONV: begin
        cmd.feed  = tcnt < TW'(VALUE_W);
        tcnt_next = tcnt + TW'(1);
        if (tcnt == TW'(CONV_LAST)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.top_sig) begin
          count_next = COUNT_W'(MAX_DIGITS) - COUNT_W'(skips);
          state_next = ST_EMIT;
        end else begin
          cmd.shift  = 1'b1;
          skips_next = skips + KW'(1);
        end
      end
      ST_EMIT: begin
        strobe      = 1'b1;
        cmd.emit    = 1'b1;
        cmd.shift   = 1'b1;
        digit_count = count;
        last_digit  = COUNT_W'(ecnt) == (count - COUNT_W'(1));
        ecnt_next   = ecnt + KW'(1);
        if (last_digit) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        strobe     = 1'b1;
        bad_radix  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/unsigned_to_radix_digits_unit.sv
// unsigned_to_radix_digits_unit: one 64-bit value in, its digits in base 2..36 out
// as ascii, most significant first; a bad base gives one flagged transfer
// a valid item keeps busy high through the conversion in the skewed cell row,
// the leading zero skip and the shift-out of the digit row, up to its last digit;
// start is taken only while busy is low; a bad base keeps busy high for its
// flagged transfer; results cannot be stalled; rst is synchronous
module unsigned_to_radix_digits_unit #(
  parameter int MAX_DIGITS = utrd_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [utrd_pkg::VALUE_W-1:0]  value,
  input  logic [utrd_pkg::RADIX_W-1:0]  radix,
  output logic                          strobe,
  output logic [utrd_pkg::CHAR_W-1:0]   digit_char,
  output logic [utrd_pkg::COUNT_W-1:0]  digit_count,
  output logic                          last_digit,
  output logic                          bad_radix
);
  import utrd_pkg::*;

  utrd_cmd_t cmd;
  utrd_sts_t sts;

  utrd_ctrl #(.MAX_DIGITS(MAX_DIGITS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .strobe      (strobe),
    .digit_count (digit_count),
    .last_digit  (last_digit),
    .bad_radix   (bad_radix)
  );

  utrd_dp #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .radix      (radix),
    .sts        (sts),
    .digit_char (digit_char)
  );

endmodule

>>> rtl/utrd_checker.sv
// utrd_checker: port-level assertions for unsigned_to_radix_digits_unit
// and the bind that attaches them; uses utrd_pkg
module utrd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          strobe,
  input logic [utrd_pkg::CHAR_W-1:0]   digit_char,
  input logic [utrd_pkg::COUNT_W-1:0]  digit_count,
  input logic                          last_digit,
  input logic                          bad_radix
);
  import utrd_pkg::*;

  // error transfer carries nothing else
  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    bad_radix |-> strobe && !last_digit && digit_count == '0 && digit_char == '0)
    else $error("bad radix transfer carries data");

  // digit transfers hold a legal glyph and a nonzero count
  a_glyph: assert property (@(posedge clk) disable iff (rst)
    strobe && !bad_radix |-> digit_count != '0 &&
      ((digit_char >= CHAR_ZERO && digit_char <= 7'd57) ||
       (digit_char >= CHAR_A && digit_char <= 7'd90)))
    else $error("illegal digit transfer");

  // digits of one conversion come back to back with one count
  a_run: assert property (@(posedge clk) disable iff (rst)
    strobe && !bad_radix && !last_digit |=> strobe && !bad_radix && $stable(digit_count))
    else $error("digit run broken");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("transfer while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item left no work");

endmodule

bind unsigned_to_radix_digits_unit utrd_checker u_utrd_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .digit_char  (digit_char),
  .digit_count (digit_count),
  .last_digit  (last_digit),
  .bad_radix   (bad_radix)
);
